// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, masked while reset is low.
`define TBRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent, masked while reset is low.
`define TBRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent, live during reset too.
`define TBRL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/tbrl_pkg.sv -----
// Shared types and constants of the token bucket limiter.
package tbrl_pkg;

    localparam int unsigned TOK_W  = 32;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned REM_W  = 30;

    typedef logic [TOK_W-1:0]  t_tok;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [REM_W-1:0]  t_rem;

    // Nanoseconds per second; fits the 30-bit remainder.
    localparam t_rem NS_PER_SEC = 30'd1000000000;

    localparam t_tok RATE_RESET  = 32'd1000000;
    localparam t_tok BURST_RESET = 32'd64;

    // Configuration register indexes.
    localparam logic [0:0] REG_RATE  = 1'b0;
    localparam logic [0:0] REG_BURST = 1'b1;

    // Quotient bits per division step, and step count for 32 bits.
    localparam int unsigned DIV_BITS  = 2;
    localparam int unsigned DIV_STEPS = TOK_W / DIV_BITS;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

endpackage

// ----- rtl/core/tbrl_mul.sv -----
// Registered 32x32 multiplier shared by the refill sequence.
module tbrl_mul
    import tbrl_pkg::*;
(
    input  logic                 i_clk,
    input  t_tok                 i_a,
    input  t_tok                 i_b,
    output logic [2*TOK_W-1:0]   o_p
);

    logic [2*TOK_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/tbrl_div_step.sv -----
// Two restoring division steps by one second in nanoseconds.
module tbrl_div_step
    import tbrl_pkg::*;
(
    input  t_rem                 i_rem,
    input  logic [DIV_BITS-1:0]  i_bits,
    output t_rem                 o_rem,
    output logic [DIV_BITS-1:0]  o_q
);

    logic [REM_W:0] s1_trial;
    logic [REM_W:0] s2_trial;
    t_rem           s1_rem;

    always_comb begin
        s1_trial = {i_rem, i_bits[1]};
        o_q[1]   = (s1_trial >= {1'b0, NS_PER_SEC});
        s1_rem   = o_q[1] ? REM_W'(s1_trial - {1'b0, NS_PER_SEC}) : s1_trial[REM_W-1:0];
        s2_trial = {s1_rem, i_bits[0]};
        o_q[0]   = (s2_trial >= {1'b0, NS_PER_SEC});
        o_rem    = o_q[0] ? REM_W'(s2_trial - {1'b0, NS_PER_SEC}) : s2_trial[REM_W-1:0];
    end

endmodule

// ----- rtl/core/token_bucket_rate_limiter.sv -----
// Token bucket rate limiter: top level with refill sequencer and token state.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_kind, i_now_ns, i_request_count
//   out     | output    | o_out_valid / i_out_ready| o_granted, o_tokens_left
//   cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// A consume word that refills goes from accept to result through prepare,
// two passes through the shared 32x32 multiplier, a combine, 16 passes through
// the two-bit division step, then refill, grant and result. A saturated refill
// skips the division, no refill skips the multiplier too, a restart goes to result.
// One word is in flight at a time; o_in_ready is high only while idle.
// A finished result waits in the output register; the next word may be
// accepted meanwhile, and its result waits for the register to drain.
// Reset is synchronous active low and restores the configuration defaults,
// a full bucket of 64 tokens and a last refill time of zero.
module token_bucket_rate_limiter
    import tbrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  t_time       i_now_ns,
    input  t_tok        i_request_count,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_tok        o_granted,
    output t_tok        o_tokens_left,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  t_tok        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MLO,
        S_MHI,
        S_SUM,
        S_DIV,
        S_UPD,
        S_GRANT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_kind;
    t_time               r_now;
    t_tok                r_req;
    t_tok                r_tok;
    t_time               r_last;
    t_tok                r_rate;
    t_tok                r_burst;
    t_time               r_elapsed;
    logic                r_refill;
    logic [2*TOK_W-1:0]  r_plo;
    t_rem                r_rem;
    t_tok                r_q;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_sat;
    t_tok                r_grant;
    logic                r_out_valid;
    t_tok                r_out_granted;
    t_tok                r_out_left;

    logic                accept;
    t_tok                tok_clamp;
    logic                advanced;
    t_tok                mul_a;
    logic [2*TOK_W-1:0]  mul_p;
    t_time               upper;
    logic                upper_sat;
    t_rem                step_rem;
    logic [DIV_BITS-1:0] step_q;
    t_tok                add_amt;
    logic [TOK_W:0]      refill_sum;
    t_tok                grant;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;

    // Clamp the stored count to the burst before anything else.
    assign tok_clamp  = (r_tok > r_burst) ? r_burst : r_tok;
    assign advanced   = (r_now > r_last);

    // Low half of the elapsed time first, then the high half.
    assign mul_a = (r_state == S_MLO) ? r_elapsed[TOK_W-1:0] : r_elapsed[TIME_W-1:TOK_W];

    tbrl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_rate),
        .o_p   (mul_p)
    );

    // Bits 95:32 of the product; quotient overflows 32 bits once this
    // reaches one second.
    assign upper     = mul_p + {{TOK_W{1'b0}}, r_plo[2*TOK_W-1:TOK_W]};
    assign upper_sat = (upper >= {{(TIME_W-REM_W){1'b0}}, NS_PER_SEC});

    // Dividend bits leave r_q at the top while quotient bits enter below.
    tbrl_div_step u_div_step (
        .i_rem  (r_rem),
        .i_bits (r_q[TOK_W-1:TOK_W-DIV_BITS]),
        .o_rem  (step_rem),
        .o_q    (step_q)
    );

    assign add_amt    = r_sat ? '1 : r_q;
    assign refill_sum = {1'b0, r_tok} + {1'b0, add_amt};
    assign grant      = (r_req < r_tok) ? r_req : r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tok       <= BURST_RESET;
            r_last      <= '0;
            r_rate      <= RATE_RESET;
            r_burst     <= BURST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RATE:  r_rate  <= i_cfg_data;
                    REG_BURST: r_burst <= i_cfg_data;
                endcase
            end

            // Load a finished result when the output register is free or drains
            // this cycle; otherwise drop the result once taken.
            if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= i_kind;
                        r_now  <= i_now_ns;
                        r_req  <= i_request_count;
                        if (i_kind) begin
                            // Restart: fill up and take the timestamp.
                            r_tok   <= r_burst;
                            r_last  <= i_now_ns;
                            r_grant <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_tok   <= tok_clamp;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_elapsed <= r_now - r_last;
                    r_refill  <= advanced && (r_rate != '0);
                    if (advanced && (r_rate == '0)) begin
                        r_last <= r_now;
                    end
                    r_state <= (advanced && (r_rate != '0)) ? S_MLO : S_UPD;
                end
                S_MLO: begin
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    // Hold the low partial product.
                    r_plo   <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sat   <= upper_sat;
                    r_rem   <= upper[REM_W-1:0];
                    r_q     <= r_plo[TOK_W-1:0];
                    r_cnt   <= '0;
                    r_state <= upper_sat ? S_UPD : S_DIV;
                end
                S_DIV: begin
                    r_rem <= step_rem;
                    r_q   <= {r_q[TOK_W-DIV_BITS-1:0], step_q};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    // Keep the refill time when nothing was added so fractions build up.
                    if (r_refill && (add_amt != '0)) begin
                        r_tok  <= (refill_sum > {1'b0, r_burst}) ? r_burst
                                                                 : refill_sum[TOK_W-1:0];
                        r_last <= r_now;
                    end
                    r_state <= S_GRANT;
                end
                S_GRANT: begin
                    r_grant <= grant;
                    r_tok   <= r_tok - grant;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_granted <= r_kind ? '0 : r_grant;
                        r_out_left    <= r_tok;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_out_granted;
    assign o_tokens_left = r_out_left;

endmodule

// ----- rtl/core/tbrl_checker.sv -----
// Port-level checker for the token bucket limiter, bound to the top level.
`include "assert_macros.svh"

module tbrl_checker
    import tbrl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  o_in_ready,
    input  logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_tok  o_granted,
    input  t_tok  o_tokens_left
);

    `TBRL_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid && o_in_ready)
    `TBRL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `TBRL_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready))
    `TBRL_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_granted) && $stable(o_tokens_left))

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (.*);
